// ===== sv/radix_trie_sparse_map_defines.svh =====
// Assertion helpers shared by the trie map RTL.
`ifndef RADIX_TRIE_SPARSE_MAP_DEFINES_SVH
`define RADIX_TRIE_SPARSE_MAP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rts_pkg.sv =====
package rts_pkg;

  localparam int LEVEL_BITS   = 8;
  localparam int TRIE_LEVELS  = 4;
  // Must be a power of two; the digit is reduced by keeping its low bits.
  localparam int NODE_ENTRIES = 256;
  localparam int POOL_NODES   = 1024;
  localparam int VALUE_WIDTH  = 32;

  localparam int IDX_W    = 32;
  localparam int DATA_W   = 32;
  localparam int DIGIT_W  = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
  localparam int NODE_W   = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int NFREE_W  = NODE_W + 1;
  localparam int LEVEL_W  = (TRIE_LEVELS > 1) ? $clog2(TRIE_LEVELS) : 1;
  localparam int ADDR_W   = NODE_W + DIGIT_W;
  localparam int DEPTH    = POOL_NODES * NODE_ENTRIES;
  localparam int ENTRY_W  = (VALUE_WIDTH > NFREE_W) ? VALUE_WIDTH : NFREE_W;
  localparam int SHIFT_W  = 8;

  localparam logic [LEVEL_W-1:0] LVL_TOP   = LEVEL_W'(TRIE_LEVELS - 1);
  localparam logic [63:0]        DIGIT_MASK = 64'((65'd1 << LEVEL_BITS) - 65'd1);
  localparam logic [DATA_W-1:0]  VALUE_MASK = DATA_W'(~64'd0 >> (64 - VALUE_WIDTH));

  localparam logic OP_LOOKUP   = 1'b0;
  localparam logic OP_PUT      = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } rts_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              status;
  } rts_out_t;

  typedef struct packed {
    logic               re;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } rts_mem_req_t;

  typedef struct packed {
    logic     valid;
    rts_out_t item;
  } rts_res_t;

  typedef struct packed {
    logic               idle;
    logic [NFREE_W-1:0] nfree;
  } rts_walk_stat_t;

  // Digit of one trie level; levels whose shift runs past the key give 0.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [IDX_W-1:0] idx,
                                                  input logic [LEVEL_W-1:0] lvl);
    logic [SHIFT_W-1:0] sh;
    logic [63:0]        wide;
    sh = SHIFT_W'(lvl) * SHIFT_W'(LEVEL_BITS);
    if (sh >= SHIFT_W'(64)) begin
      wide = '0;
    end else begin
      wide = 64'(idx) >> sh;
    end
    return DIGIT_W'(wide & DIGIT_MASK);
  endfunction

endpackage

// ===== sv/rts_node_ram.sv =====
module rts_node_ram (
  input  logic                          clk_i,
  input  rts_pkg::rts_mem_req_t         req_i,
  output logic [rts_pkg::ENTRY_W-1:0]   rdata_o
);

  logic [rts_pkg::ENTRY_W-1:0] mem [rts_pkg::DEPTH];
  logic [rts_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rts_walk_ctrl.sv =====
module rts_walk_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rts_pkg::rts_in_t            item_i,
  input  logic                        res_ready_i,
  input  logic [rts_pkg::ENTRY_W-1:0] rdata_i,
  output rts_pkg::rts_mem_req_t       mem_req_o,
  output rts_pkg::rts_res_t           res_o,
  output rts_pkg::rts_walk_stat_t     stat_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;

  logic [1:0]                     state_q, state_d;
  rts_pkg::rts_in_t               item_q, item_d;
  logic [rts_pkg::NODE_W-1:0]     node_q, node_d;
  logic [rts_pkg::LEVEL_W-1:0]    lvl_q, lvl_d;
  logic [rts_pkg::NFREE_W-1:0]    nfree_q, nfree_d;

  logic [rts_pkg::NODE_W-1:0]     child;
  logic                           pool_short;
  logic                           finish;
  rts_pkg::rts_out_t              res_item;

  // Out-of-pool child numbers count as empty.
  assign child = (rdata_i < rts_pkg::ENTRY_W'(rts_pkg::POOL_NODES))
               ? rdata_i[rts_pkg::NODE_W-1:0] : '0;
  assign pool_short = ({1'b0, nfree_q} + (rts_pkg::NFREE_W + 1)'(lvl_q))
                    > (rts_pkg::NFREE_W + 1)'(rts_pkg::POOL_NODES);

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    node_d    = node_q;
    lvl_d     = lvl_q;
    nfree_d   = nfree_q;
    mem_req_o = '0;
    finish    = 1'b0;
    res_item  = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d         = item_i;
          node_d         = '0;
          lvl_d          = rts_pkg::LVL_TOP;
          if (item_i.operation == rts_pkg::OP_PUT && rts_pkg::LVL_TOP == '0) begin
            state_d = ST_ALLOC;
          end else begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = {rts_pkg::NODE_W'(0),
                              rts_pkg::digit_of(item_i.index, rts_pkg::LVL_TOP)};
            state_d        = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (lvl_q == '0) begin
          finish              = 1'b1;
          res_item.read_value = rts_pkg::DATA_W'(rdata_i) & rts_pkg::VALUE_MASK;
        end else if (child == '0) begin
          if (item_q.operation == rts_pkg::OP_LOOKUP) begin
            finish = 1'b1;
          end else if (pool_short) begin
            finish          = 1'b1;
            res_item.status = rts_pkg::STATUS_FULL;
          end else begin
            state_d = ST_ALLOC;
          end
        end else if (item_q.operation == rts_pkg::OP_PUT
                     && lvl_q == rts_pkg::LEVEL_W'(1)) begin
          node_d  = child;
          lvl_d   = '0;
          state_d = ST_ALLOC;
        end else begin
          node_d         = child;
          lvl_d          = lvl_q - rts_pkg::LEVEL_W'(1);
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = {child,
                            rts_pkg::digit_of(item_q.index, lvl_q - rts_pkg::LEVEL_W'(1))};
        end
        if (finish && res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_ALLOC: begin
        if (lvl_q == '0) begin
          finish = 1'b1;
          if (res_ready_i) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.addr  = {node_q, rts_pkg::digit_of(item_q.index, '0)};
            mem_req_o.wdata = rts_pkg::ENTRY_W'(item_q.value & rts_pkg::VALUE_MASK);
            state_d         = ST_IDLE;
          end
        end else begin
          // Link a fresh node; its entries are still zero from the clear pass.
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = {node_q, rts_pkg::digit_of(item_q.index, lvl_q)};
          mem_req_o.wdata = rts_pkg::ENTRY_W'(nfree_q);
          node_d          = nfree_q[rts_pkg::NODE_W-1:0];
          nfree_d         = nfree_q + rts_pkg::NFREE_W'(1);
          lvl_d           = lvl_q - rts_pkg::LEVEL_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.valid = finish && res_ready_i;
  assign res_o.item  = res_item;
  assign stat_o.idle  = (state_q == ST_IDLE);
  assign stat_o.nfree = nfree_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nfree_q <= rts_pkg::NFREE_W'(1);
    end else begin
      state_q <= state_d;
      nfree_q <= nfree_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    node_q <= node_d;
    lvl_q  <= lvl_d;
  end

endmodule

// ===== sv/radix_trie_sparse_map.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | in_item_i  (rts_in_t)
// out     | output    | out_valid_o / out_ready_i| out_item_o (rts_out_t)
//
// One item at a time; the single node memory port takes one access per cycle.
// Lookup: one node read per level from the top down; an empty child ends it early.
// Put: walks the existing path, links a fresh node for each missing level, then writes.
// Reset starts a clear pass over all 262144 entries, one entry per cycle; no item
// is accepted until it ends.
// A result waiting in the output register stalls only the final step.
`include "radix_trie_sparse_map_defines.svh"

module radix_trie_sparse_map (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rts_pkg::rts_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rts_pkg::rts_out_t out_item_o
);

  localparam logic [rts_pkg::ADDR_W-1:0] CLR_LAST = rts_pkg::ADDR_W'(rts_pkg::DEPTH - 1);

  // Clear sequencer: sweep the whole store to zero after reset.
  logic                        clr_busy_q, clr_busy_d;
  logic [rts_pkg::ADDR_W-1:0]  clr_addr_q, clr_addr_d;

  rts_pkg::rts_mem_req_t       walk_req;
  rts_pkg::rts_mem_req_t       mem_req;
  logic [rts_pkg::ENTRY_W-1:0] mem_rdata;
  rts_pkg::rts_res_t           res;
  rts_pkg::rts_walk_stat_t     stat;

  // Output register parts the result side from the walk.
  logic                        out_valid_q, out_valid_d;
  rts_pkg::rts_out_t           out_item_q;
  logic                        res_ready;
  logic                        start;

  assign in_ready_o = stat.idle && !clr_busy_q;
  assign start      = in_valid_i && in_ready_o;
  assign res_ready  = !out_valid_q || out_ready_i;

  rts_walk_ctrl u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (in_item_i),
    .res_ready_i (res_ready),
    .rdata_i     (mem_rdata),
    .mem_req_o   (walk_req),
    .res_o       (res),
    .stat_o      (stat)
  );

  // Give the clear pass the memory port while it runs.
  always_comb begin
    if (clr_busy_q) begin
      mem_req       = '0;
      mem_req.we    = 1'b1;
      mem_req.addr  = clr_addr_q;
    end else begin
      mem_req = walk_req;
    end
  end

  rts_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + rts_pkg::ADDR_W'(1);
      if (clr_addr_q == CLR_LAST) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // Load a fresh result, or drop the old one once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A new result never lands on one that is still waiting.
  `RTS_ASSERT_NOW(a_no_overwrite, res.valid, !out_valid_q || out_ready_i, "result overwritten")
  // The free pointer never runs past the pool.
  `RTS_ASSERT_NOW(a_pool_bound, 1'b1, stat.nfree <= rts_pkg::NFREE_W'(rts_pkg::POOL_NODES), "pool overrun")
  // The walk only runs once the clear pass is over.
  `RTS_ASSERT_NOW(a_walk_after_clear, !stat.idle, !clr_busy_q, "walk during clear")
  // The clear pass ends right after the last entry is written.
  `RTS_ASSERT_NEXT(a_clear_end, clr_busy_q && clr_addr_q == CLR_LAST, !clr_busy_q, "clear overrun")

endmodule
